### rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and helper functions for the square-wave channel core
// with its period sweep unit.
// ----------------------------------------------------------------------------
package pts_pkg;

  typedef enum logic [1:0] {
    OP_REG_WRITE  = 2'd0,
    OP_TIMER_TICK = 2'd1,
    OP_HALF_FRAME = 2'd2
  } op_t;

  localparam logic [1:0] REG_DUTY       = 2'd0;
  localparam logic [1:0] REG_SWEEP      = 2'd1;
  localparam logic [1:0] REG_PERIOD_LO  = 2'd2;
  localparam logic [1:0] REG_PERIOD_HI  = 2'd3;

  localparam int unsigned PERIOD_W   = 11;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned SWEEP_W    = 3;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd8;

  // One row per duty setting, bit n is the output at sequencer step n.
  localparam logic [7:0] DUTY_ROW [4] = '{
    8'b0000_0010,
    8'b0000_0110,
    8'b0001_1110,
    8'b1111_1001
  };

  typedef struct packed {
    logic [PERIOD_W-1:0] value;
    logic                over;
  } target_t;

  function automatic logic duty_bit(input logic [1:0] mode, input logic [STEP_W-1:0] step);
    logic [7:0] row;
    row = DUTY_ROW[mode];
    return row[step];
  endfunction

  // Target: period + (period>>shift), or minus it and ones_comp, floored at 0.
  function automatic target_t sweep_target(input logic [PERIOD_W-1:0] period,
                                           input logic [SWEEP_W-1:0] shift,
                                           input logic subtract,
                                           input logic ones_comp);
    logic [PERIOD_W-1:0] delta;
    logic [PERIOD_W:0]   sum;
    logic [PERIOD_W:0]   take;
    target_t             t;
    delta = period >> shift;
    sum   = {1'b0, period} + {1'b0, delta};
    take  = {1'b0, delta} + {{PERIOD_W{1'b0}}, ones_comp};
    if (!subtract) begin
      t.value = sum[PERIOD_W-1:0];
      t.over  = sum[PERIOD_W];
    end else begin
      t.over = 1'b0;
      if (take > {1'b0, period}) begin
        t.value = '0;
      end else begin
        t.value = period - take[PERIOD_W-1:0];
      end
    end
    return t;
  endfunction

  function automatic logic channel_muted(input logic [PERIOD_W-1:0] period,
                                         input target_t t);
    return (period < PERIOD_MIN) || t.over;
  endfunction

endpackage

### rtl/core/pulse_timer_duty_sweep_top.sv
// ----------------------------------------------------------------------------
// pulse_timer_duty_sweep_top
// Square-wave channel core: duty sequencer, down-counting timer and period
// sweep, driven by register writes, timer ticks and half-frame ticks.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                      Contents
// s_        in   s_tvalid s_tready            tdata: write_data[7:0]
//                s_tdata s_tuser              tuser: operation[1:0] reg_select[3:2]
// m_        out  m_tvalid m_tready m_tdata    tdata: wave_high[0] muted[1]
//                                                    period[12:2], zero pad
// cfg_      in   cfg_wr_en cfg_wr_data        negate_ones_complement
//
// Every request gives exactly one result: it passes through the input
// register, then the result register.
// One request is accepted per cycle while the result is not stalled; the single
// state update and sweep target calculation between the two registers set that rate.
// A stalled result holds the input register, which then holds s_tready low.
// Reset is synchronous and clears all channel state; the ones-complement
// setting resets to one.
// ----------------------------------------------------------------------------
module pulse_timer_duty_sweep_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // write_data
  input  logic [3:0]  s_tuser,   // operation, reg_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // wave_high, muted, period, zero pad
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam int unsigned PW = pts_pkg::PERIOD_W;
  localparam int unsigned SW = pts_pkg::STEP_W;
  localparam int unsigned DW = pts_pkg::SWEEP_W;

  logic          negate_ones_complement;

  logic          in_valid;
  logic [1:0]    in_op;
  logic [1:0]    in_sel;
  logic [7:0]    in_data;
  logic          advance;

  logic [1:0]    duty_mode, duty_mode_next;
  logic          sweep_on, sweep_on_next;
  logic [DW-1:0] sweep_divider_period, sweep_divider_period_next;
  logic          sweep_subtract, sweep_subtract_next;
  logic [DW-1:0] sweep_shift_amount, sweep_shift_amount_next;
  logic          sweep_reload_flag, sweep_reload_flag_next;
  logic [PW-1:0] period_value, period_value_next;
  logic [PW-1:0] timer_count, timer_count_next;
  logic [SW-1:0] step_index, step_index_next;
  logic [DW-1:0] sweep_count, sweep_count_next;

  pts_pkg::target_t cur_target;
  pts_pkg::target_t new_target;
  logic             cur_muted;

  logic          out_valid;
  logic          out_wave;
  logic          out_muted;
  logic [PW-1:0] out_period;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      negate_ones_complement <= 1'b1;
    end else if (cfg_wr_en) begin
      negate_ones_complement <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser[1:0];
      in_sel  <= s_tuser[3:2];
      in_data <= s_tdata;
    end
  end

  always_comb begin
    cur_target = pts_pkg::sweep_target(period_value, sweep_shift_amount,
                                       sweep_subtract, negate_ones_complement);
    cur_muted  = pts_pkg::channel_muted(period_value, cur_target);

    duty_mode_next            = duty_mode;
    sweep_on_next             = sweep_on;
    sweep_divider_period_next = sweep_divider_period;
    sweep_subtract_next       = sweep_subtract;
    sweep_shift_amount_next   = sweep_shift_amount;
    sweep_reload_flag_next    = sweep_reload_flag;
    period_value_next         = period_value;
    timer_count_next          = timer_count;
    step_index_next           = step_index;
    sweep_count_next          = sweep_count;

    case (pts_pkg::op_t'(in_op))
      pts_pkg::OP_REG_WRITE: begin
        case (in_sel)
          pts_pkg::REG_DUTY: begin
            duty_mode_next = in_data[7:6];
          end
          pts_pkg::REG_SWEEP: begin
            sweep_on_next             = in_data[7];
            sweep_divider_period_next = in_data[6:4];
            sweep_subtract_next       = in_data[3];
            sweep_shift_amount_next   = in_data[2:0];
            sweep_reload_flag_next    = 1'b1;
          end
          pts_pkg::REG_PERIOD_LO: begin
            period_value_next = {period_value[PW-1:8], in_data};
          end
          default: begin
            period_value_next = {in_data[2:0], period_value[7:0]};
            step_index_next   = '0;
          end
        endcase
      end
      pts_pkg::OP_TIMER_TICK: begin
        if (timer_count == '0) begin
          timer_count_next = period_value;
          step_index_next  = step_index + SW'(1);
        end else begin
          timer_count_next = timer_count - PW'(1);
        end
      end
      pts_pkg::OP_HALF_FRAME: begin
        if (sweep_count == '0 && sweep_on && sweep_shift_amount != '0 && !cur_muted) begin
          period_value_next = cur_target.value;
        end
        if (sweep_count == '0 || sweep_reload_flag) begin
          sweep_count_next       = sweep_divider_period;
          sweep_reload_flag_next = 1'b0;
        end else begin
          sweep_count_next = sweep_count - DW'(1);
        end
      end
      default: begin
      end
    endcase

    new_target = pts_pkg::sweep_target(period_value_next, sweep_shift_amount_next,
                                       sweep_subtract_next, negate_ones_complement);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_mode            <= '0;
      sweep_on             <= 1'b0;
      sweep_divider_period <= '0;
      sweep_subtract       <= 1'b0;
      sweep_shift_amount   <= '0;
      sweep_reload_flag    <= 1'b0;
      period_value         <= '0;
      timer_count          <= '0;
      step_index           <= '0;
      sweep_count          <= '0;
    end else if (advance) begin
      duty_mode            <= duty_mode_next;
      sweep_on             <= sweep_on_next;
      sweep_divider_period <= sweep_divider_period_next;
      sweep_subtract       <= sweep_subtract_next;
      sweep_shift_amount   <= sweep_shift_amount_next;
      sweep_reload_flag    <= sweep_reload_flag_next;
      period_value         <= period_value_next;
      timer_count          <= timer_count_next;
      step_index           <= step_index_next;
      sweep_count          <= sweep_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_wave   <= pts_pkg::duty_bit(duty_mode_next, step_index_next);
      out_muted  <= pts_pkg::channel_muted(period_value_next, new_target);
      out_period <= period_value_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_period, out_muted, out_wave};

endmodule

### tb/sv/tb_pulse_timer_duty_sweep_top.sv
// ----------------------------------------------------------------------------
// tb_pulse_timer_duty_sweep_top
// Self-checking bench for the square-wave channel core. Register writes,
// timer ticks and half-frame ticks go in over the request stream. A channel
// model in the bench predicts duty bit, mute flag and period for each
// request, and every result is checked against it in order. Directed tests
// cover field extremes and the sweep corner cases. Random traffic then runs
// under both negate modes, with random stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_pulse_timer_duty_sweep_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [7:0] DUTY_PATTERN [4] = '{
    8'b0000_0010,
    8'b0000_0110,
    8'b0001_1110,
    8'b1111_1001
  };

  typedef struct packed {
    logic        wave;
    logic        mute;
    logic [10:0] period;
  } chan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  chan_result_t chan_results_q [$];
  int unsigned  error_count = 0;
  bit           quiet = 1'b0;
  int unsigned  hold_request = 0;
  int unsigned  hold_left = 0;

  // Channel model state.
  logic        ones_comp = 1'b1;
  logic [1:0]  duty_mode = '0;
  logic        sweep_en = 1'b0;
  logic [2:0]  sweep_div = '0;
  logic        sweep_neg = 1'b0;
  logic [2:0]  sweep_shift = '0;
  logic        sweep_reload = 1'b0;
  logic [10:0] period_q = '0;
  logic [10:0] timer_q = '0;
  logic [2:0]  step_q = '0;
  logic [2:0]  sweep_cnt = '0;

  pulse_timer_duty_sweep_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic logic [11:0] sweep_goal();
    logic [10:0] delta;
    logic [11:0] take;
    delta = period_q >> sweep_shift;
    if (!sweep_neg) begin
      return {1'b0, period_q} + {1'b0, delta};
    end
    take = {1'b0, delta} + {11'd0, ones_comp};
    if (take > {1'b0, period_q}) begin
      return '0;
    end
    return {1'b0, period_q} - take;
  endfunction

  function automatic logic channel_silent();
    return (period_q < pts_pkg::PERIOD_MIN) || (sweep_goal() > 12'h7FF);
  endfunction

  task automatic predict_channel(input logic [1:0] op, input logic [1:0] sel,
                                 input logic [7:0] data);
    chan_result_t r;
    logic [11:0]  goal;
    case (op)
      pts_pkg::OP_REG_WRITE: begin
        case (sel)
          pts_pkg::REG_DUTY: duty_mode = data[7:6];
          pts_pkg::REG_SWEEP: begin
            sweep_en = data[7];
            sweep_div = data[6:4];
            sweep_neg = data[3];
            sweep_shift = data[2:0];
            sweep_reload = 1'b1;
          end
          pts_pkg::REG_PERIOD_LO: period_q[7:0] = data;
          default: begin
            period_q[10:8] = data[2:0];
            step_q = '0;
          end
        endcase
      end
      pts_pkg::OP_TIMER_TICK: begin
        if (timer_q == '0) begin
          timer_q = period_q;
          step_q = step_q + 3'd1;
        end else begin
          timer_q = timer_q - 11'd1;
        end
      end
      pts_pkg::OP_HALF_FRAME: begin
        goal = sweep_goal();
        if (sweep_cnt == '0 && sweep_en && sweep_shift != '0 && !channel_silent()) begin
          period_q = goal[10:0];
        end
        if (sweep_cnt == '0 || sweep_reload) begin
          sweep_cnt = sweep_div;
          sweep_reload = 1'b0;
        end else begin
          sweep_cnt = sweep_cnt - 3'd1;
        end
      end
      default: ;
    endcase
    r.wave = DUTY_PATTERN[duty_mode][step_q];
    r.mute = channel_silent();
    r.period = period_q;
    chan_results_q.push_back(r);
  endtask

  task automatic send_request(input logic [1:0] op, input logic [1:0] sel,
                              input logic [7:0] data);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {sel, op};
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    predict_channel(op, sel, data);
  endtask

  task automatic send_write(input logic [1:0] sel, input logic [7:0] data);
    send_request(pts_pkg::OP_REG_WRITE, sel, data);
  endtask

  task automatic send_tick(input logic [1:0] op);
    send_request(op, 2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic drain_channel();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (chan_results_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_negate_mode(input logic mode);
    drain_channel();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    ones_comp = mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin : check_result
    chan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (chan_results_q.size() == 0) begin
        $error("result %h arrived with no request outstanding", m_tdata);
        error_count++;
      end else begin
        want = chan_results_q.pop_front();
        if (m_tdata[0] !== want.wave) begin
          $error("wave_high: expected %0d, got %0d", want.wave, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[1] !== want.mute) begin
          $error("muted: expected %0d, got %0d", want.mute, m_tdata[1]);
          error_count++;
        end
        if (m_tdata[12:2] !== want.period) begin
          $error("period: expected %0h, got %0h", want.period, m_tdata[12:2]);
          error_count++;
        end
      end
    end
  end

  task automatic test_reset_state();
    send_request(OP_UNUSED, 2'd3, 8'hFF);
  endtask

  task automatic test_register_writes();
    send_write(pts_pkg::REG_DUTY, 8'hFF);
    send_write(pts_pkg::REG_PERIOD_LO, 8'hFF);
    send_write(pts_pkg::REG_PERIOD_HI, 8'hFF);
    send_write(pts_pkg::REG_SWEEP, 8'hFF);
    send_write(pts_pkg::REG_SWEEP, 8'h00);
    send_write(pts_pkg::REG_DUTY, 8'h40);
    send_request(OP_UNUSED, 2'd0, 8'h00);
  endtask

  task automatic test_sequencer();
    send_write(pts_pkg::REG_PERIOD_LO, 8'h01);
    send_write(pts_pkg::REG_PERIOD_HI, 8'hF8);
    repeat (6) send_tick(pts_pkg::OP_TIMER_TICK);
  endtask

  task automatic test_sweep_add();
    send_write(pts_pkg::REG_PERIOD_HI, 8'h04);
    send_write(pts_pkg::REG_SWEEP, 8'h80);
    send_tick(pts_pkg::OP_HALF_FRAME);
    send_write(pts_pkg::REG_SWEEP, 8'h00);
    send_write(pts_pkg::REG_SWEEP, 8'h81);
    send_tick(pts_pkg::OP_HALF_FRAME);
  endtask

  task automatic test_sweep_subtract();
    set_negate_mode(1'b0);
    send_write(pts_pkg::REG_SWEEP, 8'h89);
    send_tick(pts_pkg::OP_HALF_FRAME);
    send_tick(pts_pkg::OP_HALF_FRAME);
    set_negate_mode(1'b1);
    send_write(pts_pkg::REG_SWEEP, 8'h88);
    send_tick(pts_pkg::OP_HALF_FRAME);
    send_write(pts_pkg::REG_SWEEP, 8'h8F);
    send_tick(pts_pkg::OP_HALF_FRAME);
  endtask

  task automatic send_random_request();
    int unsigned kind;
    logic [1:0]  sel;
    logic [7:0]  data;
    kind = $urandom_range(99);
    sel = 2'($urandom_range(3));
    data = 8'($urandom_range(255));
    if (kind < 45) begin
      send_request(pts_pkg::OP_TIMER_TICK, sel, data);
    end else if (kind < 65) begin
      send_request(pts_pkg::OP_HALF_FRAME, sel, data);
    end else if (kind < 95) begin
      if (sel == pts_pkg::REG_PERIOD_HI && $urandom_range(3) != 0) begin
        data[2:0] = '0;
      end
      if (sel == pts_pkg::REG_PERIOD_LO && $urandom_range(1) != 0) begin
        data = 8'($urandom_range(15));
      end
      send_write(sel, data);
    end else begin
      send_request(OP_UNUSED, sel, data);
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_random_request();
  endtask

  task automatic test_output_hold_off();
    @(negedge clk);
    hold_request = 80;
    repeat (30) send_random_request();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_register_writes();
    test_sequencer();
    test_sweep_add();
    test_sweep_subtract();
    test_random_traffic(600);
    test_output_hold_off();
    set_negate_mode(1'b0);
    quiet = 1'b1;
    test_random_traffic(600);
    quiet = 1'b0;
    set_negate_mode(1'b1);
    test_random_traffic(600);
    drain_channel();
    if (error_count == 0) begin
      $display("pulse_timer_duty_sweep_top verification clean");
    end else begin
      $display("pulse_timer_duty_sweep_top verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("pulse_timer_duty_sweep_top verification failed");
    $finish;
  end

endmodule
